### design/nrt_pkg.sv
package nrt_pkg;

   // widths of the stream payload fields
   localparam int ACTION_W    = 2;
   localparam int COLOR_W     = 4;
   localparam int PIXELS_W    = 22;
   localparam int COORD_W     = 16;
   localparam int FIELD_ID_W  = 16;
   localparam int OBJ_COUNT_W = 7;
   localparam int MMD_W       = 12;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 32;

   // squared distances: limit is (mmd*16)^2, sum of two 16 bit squares
   localparam int MMD_SQ_W = 2 * MMD_W;
   localparam int DIST_W   = 2 * COORD_W + 1;

   localparam logic [MMD_W-1:0] MMD_RESET = 12'd100;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MATCH = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

   // one stored region, without its id
   typedef struct packed {
      logic [COLOR_W-1:0]  color;
      logic [PIXELS_W-1:0] pixels;
      logic [COORD_W-1:0]  cx;
      logic [COORD_W-1:0]  cy;
   } entry_type;

   // per cell control: append write or rotate one bank
   typedef struct packed {
      logic wr_en;
      logic wr_bank;
      logic rot_en;
      logic rot_bank;
   } cell_ctrl_type;

   // control flags of the entry presented to the matcher from the head of the chain
   typedef struct packed {
      logic valid;
      logic hit;
      logic last;
   } scan_ctrl_type;

   // matcher status back to the sequencer
   typedef struct packed {
      logic done;
      logic found;
   } match_stat_type;

endpackage

### design/nrt_cell.sv
module nrt_cell #(
   parameter int ID_BITS = 16
) (
   input  logic                            clock,
   input  nrt_pkg::cell_ctrl_type          ctrl,
   input  nrt_pkg::entry_type              wr_entry,
   input  logic [ID_BITS-1:0]              wr_ident,
   input  nrt_pkg::entry_type [1:0]        rot_entry_in,
   input  logic [1:0][ID_BITS-1:0]         rot_ident_in,
   output nrt_pkg::entry_type [1:0]        entry_out,
   output logic [1:0][ID_BITS-1:0]        ident_out
);
   import nrt_pkg::*;

   entry_type [1:0]         entry_ff;
   logic [1:0][ID_BITS-1:0] ident_ff;

   // one entry per bank: append write, or take the neighbour's entry on rotate
   always_ff @(posedge clock) begin
      for (int b = 0; b < 2; b++) begin
         if (ctrl.wr_en && ctrl.wr_bank == 1'(b)) begin
            entry_ff[b] <= wr_entry;
            ident_ff[b] <= wr_ident;
         end else if (ctrl.rot_en && ctrl.rot_bank == 1'(b)) begin
            entry_ff[b] <= rot_entry_in[b];
            ident_ff[b] <= rot_ident_in[b];
         end
      end
   end

   assign entry_out = entry_ff;
   assign ident_out = ident_ff;

endmodule

### design/nrt_match.sv
module nrt_match #(
   parameter int ID_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [nrt_pkg::DIST_W-1:0]    limit_sq,
   input  nrt_pkg::entry_type            query,
   input  nrt_pkg::scan_ctrl_type        scan,
   input  nrt_pkg::entry_type            scan_entry,
   input  logic [ID_BITS-1:0]            scan_ident,
   output nrt_pkg::match_stat_type       stat,
   output logic [ID_BITS-1:0]            best_ident
);
   import nrt_pkg::*;

   logic [PIXELS_W-1:0]  small_px;
   logic [PIXELS_W-1:0]  large_px;
   logic [PIXELS_W+1:0]  small_x4;
   logic [PIXELS_W+1:0]  large_x3;
   logic                 ok1_in;
   logic [COORD_W-1:0]   dx1_in;
   logic [COORD_W-1:0]   dy1_in;

   logic                 v1_ff, last1_ff, ok1_ff;
   logic [COORD_W-1:0]   dx1_ff, dy1_ff;
   logic [ID_BITS-1:0]   id1_ff;

   logic                 v2_ff, last2_ff, ok2_ff;
   logic [2*COORD_W-1:0] sqx2_ff, sqy2_ff;
   logic [ID_BITS-1:0]   id2_ff;

   logic [DIST_W-1:0]    dist_sq;
   logic [DIST_W-1:0]    best_ff;
   logic                 found_ff;
   logic                 done_ff;
   logic [ID_BITS-1:0]   best_id_ff;

   // stage 1: colour, size ratio and centroid differences
   always_comb begin
      small_px = (scan_entry.pixels < query.pixels) ? scan_entry.pixels : query.pixels;
      large_px = (scan_entry.pixels < query.pixels) ? query.pixels : scan_entry.pixels;
      small_x4 = {small_px, 2'b00};
      large_x3 = {1'b0, large_px, 1'b0} + {2'b00, large_px};
      ok1_in   = scan.hit && (scan_entry.color == query.color) && (small_x4 > large_x3);
      dx1_in   = (scan_entry.cx > query.cx) ? scan_entry.cx - query.cx
                                            : query.cx - scan_entry.cx;
      dy1_in   = (scan_entry.cy > query.cy) ? scan_entry.cy - query.cy
                                            : query.cy - scan_entry.cy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= scan.valid;
      end
      last1_ff <= scan.last;
      ok1_ff   <= ok1_in;
      dx1_ff   <= dx1_in;
      dy1_ff   <= dy1_in;
      id1_ff   <= scan_ident;
   end

   // stage 2: squares
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      last2_ff <= last1_ff;
      ok2_ff   <= ok1_ff;
      sqx2_ff  <= dx1_ff * dx1_ff;
      sqy2_ff  <= dy1_ff * dy1_ff;
      id2_ff   <= id1_ff;
   end

   // stage 3: sum and keep the nearest, earliest wins on a tie
   assign dist_sq = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= v2_ff && last2_ff;
         if (start) begin
            found_ff <= 1'b0;
         end else if (v2_ff && ok2_ff && dist_sq < best_ff) begin
            found_ff <= 1'b1;
         end
      end
      if (start) begin
         best_ff <= limit_sq;
      end else if (v2_ff && ok2_ff && dist_sq < best_ff) begin
         best_ff    <= dist_sq;
         best_id_ff <= id2_ff;
      end
   end

   assign stat.done  = done_ff;
   assign stat.found = found_ff;
   assign best_ident = best_id_ff;

endmodule

### design/nearest_region_id_tracker_core.sv
// Region id tracker: gives each detected region a frame-to-frame id.
// req channel: one item per command; tuser carries the action (start frame,
// match region, add region with given id, clear current list), tdata the
// region fields. rsp channel: exactly one item per accepted request, with
// the id, the reuse and drop flags and the current list size.
// csr_wr_en/csr_wr_data load the match distance limit in whole pixels.
// Both region lists live in a ring of MAX_OBJECTS cells, one entry per bank
// each. A match rotates the previous-frame bank once round the ring, one
// entry per cycle into a three stage distance/compare unit; the other
// actions skip the scan and go straight to the final step. The ring
// rotation sets the rate: one item at a time, the next taken in the cycle
// after a result is registered.
// A result waits in the output register while rsp_tready is low; the next
// item is still accepted and worked on, and only its final step waits.
// Reset (synchronous) empties both lists, zeroes the id counter and sets
// the distance limit to 100; stored entries themselves are not cleared.
module nearest_region_id_tracker_core #(
   parameter int MAX_OBJECTS = 64,
   parameter int ID_BITS     = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [nrt_pkg::MMD_W-1:0]         csr_wr_data,   // max_match_distance
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // color[3:0], pixel_count[25:4], centroid_x[41:26], centroid_y[57:42],
   // given_id[73:58], zero fill [79:74]
   input  logic [nrt_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [nrt_pkg::ACTION_W-1:0]      req_tuser,     // action
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // assigned_id[15:0], reused_id[16], dropped[17], object_count[24:18],
   // zero fill [31:25]
   output logic [nrt_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import nrt_pkg::*;

   localparam int CW = $clog2(MAX_OBJECTS + 1);
   localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [MMD_W-1:0]      mmd_ff;
   logic [MMD_SQ_W-1:0]   limsq_ff;
   logic [ACTION_W-1:0]   q_action_ff;
   entry_type             q_entry_ff;
   logic [ID_BITS-1:0]    q_gid_ff;
   logic [CW-1:0]         cur_ff, cur_in;
   logic [CW-1:0]         prev_ff, prev_in;
   logic                  bank_ff, bank_in;
   logic [ID_BITS-1:0]    next_id_ff, next_id_in;
   logic [IW-1:0]         step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                  req_accept;
   logic                  out_free;
   logic                  fin_fire;
   logic                  scan_last;
   logic                  match_start;
   logic                  wr_go;
   logic                  do_append;
   logic                  reused;
   logic                  dropped;
   logic [ID_BITS-1:0]    res_id;
   entry_type             req_entry;

   entry_type [1:0]         cell_ent [MAX_OBJECTS];
   logic [1:0][ID_BITS-1:0] cell_id  [MAX_OBJECTS];
   cell_ctrl_type           cell_ctrl [MAX_OBJECTS];

   scan_ctrl_type           scan;
   match_stat_type          m_stat;
   logic [ID_BITS-1:0]      m_best_id;

   // request unpacking
   assign req_entry.color  = req_tdata[3:0];
   assign req_entry.pixels = req_tdata[25:4];
   assign req_entry.cx     = req_tdata[41:26];
   assign req_entry.cy     = req_tdata[57:42];

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   // matcher restarts in the first scan cycle, once the squared limit is loaded
   assign match_start = (state_ff == ST_SCAN) && (step_ff == '0);
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign fin_fire    = (state_ff == ST_FIN) && out_free;
   assign scan_last   = (step_ff == IW'(MAX_OBJECTS - 1));

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         mmd_ff <= MMD_RESET;
      end else if (csr_wr_en) begin
         mmd_ff <= csr_wr_data;
      end
   end

   // item capture and squared limit
   always_ff @(posedge clock) begin
      if (req_accept) begin
         q_action_ff <= req_tuser;
         q_entry_ff  <= req_entry;
         q_gid_ff    <= ID_BITS'(req_tdata[73:58]);
         limsq_ff    <= mmd_ff * mmd_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_accept) begin
               state_in = (req_tuser == ACT_MATCH) ? ST_SCAN : ST_FIN;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (m_stat.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // list bookkeeping and result for the item
   always_comb begin
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      bank_in    = bank_ff;
      next_id_in = next_id_ff;
      res_id     = '0;
      reused     = 1'b0;
      dropped    = 1'b0;
      do_append  = 1'b0;
      wr_go      = 1'b0;
      case (q_action_ff)
         ACT_START: begin
            prev_in = cur_ff;
            bank_in = ~bank_ff;
            cur_in  = '0;
         end
         ACT_CLEAR: begin
            cur_in = '0;
         end
         ACT_ADD: begin
            res_id    = q_gid_ff;
            do_append = 1'b1;
         end
         ACT_MATCH: begin
            reused    = m_stat.found;
            do_append = 1'b1;
            if (m_stat.found) begin
               res_id = m_best_id;
            end else begin
               res_id     = next_id_ff;
               next_id_in = next_id_ff + 1'b1;
            end
         end
         default: begin
            do_append = 1'b0;
         end
      endcase
      if (do_append) begin
         if (cur_ff < CW'(MAX_OBJECTS)) begin
            wr_go  = 1'b1;
            cur_in = cur_ff + 1'b1;
         end else begin
            dropped = 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_fire) begin
         rsp_data_ff <= {7'b0, OBJ_COUNT_W'(cur_in), dropped, reused,
                         FIELD_ID_W'(res_id)};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cur_ff       <= '0;
         prev_ff      <= '0;
         bank_ff      <= 1'b0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fin_fire) begin
            cur_ff     <= cur_in;
            prev_ff    <= prev_in;
            bank_ff    <= bank_in;
            next_id_ff <= next_id_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ring of entry cells; rotation moves each entry one place towards cell 0
   for (genvar k = 0; k < MAX_OBJECTS; k++) begin : g_cell
      localparam int NXT = (k + 1) % MAX_OBJECTS;

      assign cell_ctrl[k].wr_en    = fin_fire && wr_go && (cur_ff == CW'(k));
      assign cell_ctrl[k].wr_bank  = bank_ff;
      assign cell_ctrl[k].rot_en   = (state_ff == ST_SCAN);
      assign cell_ctrl[k].rot_bank = ~bank_ff;

      nrt_cell #(
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl[k]),
         .wr_entry     (q_entry_ff),
         .wr_ident     (res_id),
         .rot_entry_in (cell_ent[NXT]),
         .rot_ident_in (cell_id[NXT]),
         .entry_out    (cell_ent[k]),
         .ident_out    (cell_id[k])
      );
   end

   // head of the ring feeds the matcher, one previous-frame entry per cycle
   assign scan.valid = (state_ff == ST_SCAN);
   assign scan.hit   = (CW'(step_ff) < prev_ff);
   assign scan.last  = scan_last;

   nrt_match #(
      .ID_BITS (ID_BITS)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .start      (match_start),
      .limit_sq   ({1'b0, limsq_ff, 8'b0}),
      .query      (q_entry_ff),
      .scan       (scan),
      .scan_entry (cell_ent[0][~bank_ff]),
      .scan_ident (cell_id[0][~bank_ff]),
      .stat       (m_stat),
      .best_ident (m_best_id)
   );

   // checks
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && scan_last |=> (state_ff == ST_DRAIN))
      else $error("scan did not end after a full rotation");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      m_stat.done |-> (state_ff == ST_DRAIN))
      else $error("matcher finished outside the drain state");

   a_start_frame: assert property (@(posedge clock) disable iff (reset)
      fin_fire && (q_action_ff == ACT_START)
      |=> (cur_ff == '0) && (bank_ff != $past(bank_ff)))
      else $error("start frame did not swap banks and empty the list");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      fin_fire && dropped |-> (cur_ff == CW'(MAX_OBJECTS)))
      else $error("item dropped while the list had room");

endmodule

### tb/region_track_checker.sv
`timescale 1ns / 100ps

module region_track_checker #(
   parameter int MAX_OBJECTS = 64,
   parameter int ID_BITS     = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [nrt_pkg::MMD_W-1:0]      csr_wr_data,   // max_match_distance
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // color[3:0], pixel_count[25:4], centroid_x[41:26], centroid_y[57:42],
   // given_id[73:58], zero fill [79:74]
   input  logic [nrt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [nrt_pkg::ACTION_W-1:0]   req_tuser,     // action
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // assigned_id[15:0], reused_id[16], dropped[17], object_count[24:18],
   // zero fill [31:25]
   input  logic [nrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             mismatch_count,
   output int                             open_items
);

   localparam int BANK_DEPTH = 2 * MAX_OBJECTS;

   // one predicted result item
   typedef struct packed {
      logic [15:0] ident;
      logic        reused;
      logic        dropped;
      logic [6:0]  count;
   } region_result_type;

   // both region banks, current list in cur_bank
   logic [3:0]         bank_color  [BANK_DEPTH];
   logic [21:0]        bank_pixels [BANK_DEPTH];
   logic [15:0]        bank_cx     [BANK_DEPTH];
   logic [15:0]        bank_cy     [BANK_DEPTH];
   logic [ID_BITS-1:0] bank_ident  [BANK_DEPTH];
   int unsigned        cur_count;
   int unsigned        prev_count;
   logic               cur_bank;
   logic [ID_BITS-1:0] fresh_ident;
   logic [11:0]        match_limit;

   region_result_type pending_tracks[$];
   region_result_type want;

   // append to the current list, refused when full
   function automatic bit store_region(input logic [3:0] c, input logic [21:0] p,
                                       input logic [15:0] x, input logic [15:0] y,
                                       input logic [ID_BITS-1:0] ident);
      int unsigned slot;
      if (cur_count >= MAX_OBJECTS)
         return 1'b0;
      slot = (cur_bank ? MAX_OBJECTS : 0) + cur_count;
      bank_color[slot]  = c;
      bank_pixels[slot] = p;
      bank_cx[slot]     = x;
      bank_cy[slot]     = y;
      bank_ident[slot]  = ident;
      cur_count++;
      return 1'b1;
   endfunction

   // apply one request item to the tracker state and give its result
   function automatic region_result_type track_region(input logic [1:0] act,
                                                      input logic [79:0] d);
      logic [3:0]         c;
      logic [21:0]        p;
      logic [15:0]        x;
      logic [15:0]        y;
      logic [15:0]        gid;
      logic [63:0]        lim;
      logic [63:0]        best;
      logic [63:0]        small_px;
      logic [63:0]        large_px;
      logic [63:0]        dx;
      logic [63:0]        dy;
      logic [63:0]        d2;
      logic               found;
      logic [ID_BITS-1:0] new_id;
      int unsigned        base;
      int unsigned        s;
      region_result_type  r;
      c   = d[3:0];
      p   = d[25:4];
      x   = d[41:26];
      y   = d[57:42];
      gid = d[73:58];
      r   = '0;
      case (act)
         nrt_pkg::ACT_START: begin
            prev_count = cur_count;
            cur_bank   = ~cur_bank;
            cur_count  = 0;
         end
         nrt_pkg::ACT_CLEAR: begin
            cur_count = 0;
         end
         nrt_pkg::ACT_ADD: begin
            new_id    = ID_BITS'(gid);
            r.ident   = 16'(new_id);
            r.dropped = !store_region(c, p, x, y, new_id);
         end
         default: begin
            // nearest same-colour entry of similar size, strictly inside the limit
            lim    = 64'(match_limit) * 64'd16;
            best   = lim * lim;
            found  = 1'b0;
            new_id = '0;
            base   = cur_bank ? 0 : MAX_OBJECTS;
            for (int unsigned k = 0; k < prev_count; k++) begin
               s        = base + k;
               small_px = (64'(bank_pixels[s]) < 64'(p)) ? 64'(bank_pixels[s]) : 64'(p);
               large_px = (64'(bank_pixels[s]) < 64'(p)) ? 64'(p) : 64'(bank_pixels[s]);
               dx = (bank_cx[s] > x) ? 64'(bank_cx[s] - x) : 64'(x - bank_cx[s]);
               dy = (bank_cy[s] > y) ? 64'(bank_cy[s] - y) : 64'(y - bank_cy[s]);
               d2 = dx * dx + dy * dy;
               if (bank_color[s] == c && 64'd4 * small_px > 64'd3 * large_px && d2 < best) begin
                  best   = d2;
                  new_id = bank_ident[s];
                  found  = 1'b1;
               end
            end
            if (!found) begin
               new_id      = fresh_ident;
               fresh_ident = fresh_ident + 1'b1;
            end
            r.ident   = 16'(new_id);
            r.reused  = found;
            r.dropped = !store_region(c, p, x, y, new_id);
         end
      endcase
      r.count = 7'(cur_count);
      return r;
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at %0t: %s expected %0h got %0h",
                  $time, field, exp_val, act_val);
   endtask

   // watch both channels, predict on each request item, compare each result item
   always @(posedge clock) begin
      if (reset) begin
         cur_count   = 0;
         prev_count  = 0;
         cur_bank    = 1'b0;
         fresh_ident = '0;
         match_limit = nrt_pkg::MMD_RESET;
         pending_tracks.delete();
      end else begin
         if (csr_wr_en)
            match_limit = csr_wr_data;
         if (req_tvalid && req_tready)
            pending_tracks.insert(pending_tracks.size(),
                                  track_region(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_tracks.size() == 0) begin
               flag_mismatch("unexpected item", 32'd0, rsp_tdata);
            end else begin
               want = pending_tracks.pop_front();
               if (rsp_tdata[15:0] !== want.ident)
                  flag_mismatch("assigned_id", 32'(want.ident), 32'(rsp_tdata[15:0]));
               if (rsp_tdata[16] !== want.reused)
                  flag_mismatch("reused_id", 32'(want.reused), 32'(rsp_tdata[16]));
               if (rsp_tdata[17] !== want.dropped)
                  flag_mismatch("dropped", 32'(want.dropped), 32'(rsp_tdata[17]));
               if (rsp_tdata[24:18] !== want.count)
                  flag_mismatch("object_count", 32'(want.count), 32'(rsp_tdata[24:18]));
               if (rsp_tdata[31:25] !== 7'd0)
                  flag_mismatch("zero fill", 32'd0, 32'(rsp_tdata[31:25]));
            end
         end
      end
      open_items = pending_tracks.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int MAX_OBJECTS     = 64;
   localparam int ID_BITS         = 16;
   localparam int ITEM_TARGET     = 550;
   localparam int PHASES          = 7;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = MAX_OBJECTS + 16;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [nrt_pkg::MMD_W-1:0]      csr_wr_data;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [nrt_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [nrt_pkg::ACTION_W-1:0]   req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [nrt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   int                             mismatch_count;
   int                             open_items;

   // stimulus side copy of the region lists, only used to aim near matches
   nrt_pkg::entry_type seen_cur  [MAX_OBJECTS];
   nrt_pkg::entry_type seen_prev [MAX_OBJECTS];
   int                 seen_cur_n;
   int                 seen_prev_n;
   int                 burst_left;
   int                 items_sent;
   bit                 steady;
   logic [11:0]        limit_now;
   logic               hold_off_req;

   nearest_region_id_tracker_core #(
      .MAX_OBJECTS (MAX_OBJECTS),
      .ID_BITS     (ID_BITS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   region_track_checker #(
      .MAX_OBJECTS (MAX_OBJECTS),
      .ID_BITS     (ID_BITS)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .open_items     (open_items)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic nrt_pkg::entry_type rgn(input int c, input int p, input int x,
                                              input int y);
      nrt_pkg::entry_type e;
      e.color  = 4'(c);
      e.pixels = 22'(p);
      e.cx     = 16'(x);
      e.cy     = 16'(y);
      return e;
   endfunction

   function automatic nrt_pkg::entry_type wild_region();
      return rgn($urandom, $urandom, $urandom, $urandom);
   endfunction

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // a region close to one of the previous frame, straddling the match limit
   function automatic nrt_pkg::entry_type near_region();
      nrt_pkg::entry_type e;
      int span;
      int px;
      int ox;
      int oy;
      e = seen_prev[$urandom_range(0, seen_prev_n - 1)];
      if ($urandom_range(0, 9) == 0)
         e.color = 4'($urandom);
      px = int'(longint'(e.pixels) * longint'($urandom_range(70, 135)) / 100);
      e.pixels = 22'(clamp(px, 0, 4194303));
      span = clamp(int'(limit_now) * 24 + 24, 0, 65535);
      ox = int'($urandom_range(0, span));
      oy = int'($urandom_range(0, span / 4));
      if ($urandom_range(0, 1)) ox = -ox;
      if ($urandom_range(0, 1)) oy = -oy;
      if ($urandom_range(0, 1)) begin
         e.cx = 16'(clamp(int'(e.cx) + ox, 0, 65535));
         e.cy = 16'(clamp(int'(e.cy) + oy, 0, 65535));
      end else begin
         e.cx = 16'(clamp(int'(e.cx) + oy, 0, 65535));
         e.cy = 16'(clamp(int'(e.cy) + ox, 0, 65535));
      end
      return e;
   endfunction

   // offer one request item, wait for it to be taken, then pace the sender
   task automatic offer(input logic [1:0] act, input nrt_pkg::entry_type e,
                        input logic [15:0] gid);
      int gap;
      req_tuser  <= act;
      req_tdata  <= {6'b0, gid, e.cy, e.cx, e.pixels, e.color};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      case (act)
         nrt_pkg::ACT_START: begin
            seen_prev   = seen_cur;
            seen_prev_n = seen_cur_n;
            seen_cur_n  = 0;
         end
         nrt_pkg::ACT_CLEAR: seen_cur_n = 0;
         default: begin
            if (seen_cur_n < MAX_OBJECTS) begin
               seen_cur[seen_cur_n] = e;
               seen_cur_n++;
            end
         end
      endcase
      @(negedge clock);
      if (!steady) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 6);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
   endtask

   // one frame: start, then mostly matches aimed at the previous frame
   task automatic random_frame(input int regions);
      int pick;
      offer(nrt_pkg::ACT_START, wild_region(), 16'($urandom));
      for (int i = 0; i < regions; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            offer(2'($urandom), wild_region(), 16'($urandom));
         else if (pick < 10)
            offer(nrt_pkg::ACT_CLEAR, wild_region(), 16'($urandom));
         else if (pick < 25)
            offer(nrt_pkg::ACT_ADD, (seen_prev_n > 0 && pick < 20) ? near_region()
                                                                    : wild_region(),
                  16'($urandom));
         else if (seen_prev_n > 0 && pick < 85)
            offer(nrt_pkg::ACT_MATCH, near_region(), 16'($urandom));
         else
            offer(nrt_pkg::ACT_MATCH, wild_region(), 16'($urandom));
      end
   endtask

   // write the distance limit once all result items are out
   task automatic write_limit(input logic [11:0] v);
      req_tvalid <= 1'b0;
      while (open_items != 0) @(negedge clock);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      limit_now = v;
   endtask

   // receiver: own stall pattern, plus one long hold-off on request
   initial begin
      int  mode;
      int  span;
      bit  hold_taken;
      rsp_tready = 1'b0;
      span       = 0;
      mode       = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = (mode == 3) ? $urandom_range(1, 40) : $urandom_range(20, 300);
            end
            span--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= 1'b0;
            endcase
         end
      end
   end

   // watchdog on cycles without any accepted item
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // stimulus
   initial begin
      int phase_end;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = nrt_pkg::MMD_RESET;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = nrt_pkg::ACT_START;
      hold_off_req = 1'b0;
      seen_cur_n   = 0;
      seen_prev_n  = 0;
      burst_left   = 0;
      items_sent   = 0;
      steady       = 1'b0;
      limit_now    = nrt_pkg::MMD_RESET;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, ties, size ratio and distance edges
      write_limit(12'd100);
      offer(nrt_pkg::ACT_MATCH, rgn(0, 1, 0, 0), 16'd0);
      offer(nrt_pkg::ACT_ADD, rgn(15, 4194303, 65535, 65535), 16'hFFFF);
      offer(nrt_pkg::ACT_ADD, rgn(5, 100, 1000, 1000), 16'd10);
      offer(nrt_pkg::ACT_ADD, rgn(5, 100, 1040, 1000), 16'd11);
      offer(nrt_pkg::ACT_ADD, rgn(7, 0, 5000, 5000), 16'd0);
      offer(nrt_pkg::ACT_ADD, rgn(9, 100, 20000, 20000), 16'd12);
      offer(nrt_pkg::ACT_START, rgn(0, 0, 0, 0), 16'd0);
      // equal distance to two entries: the earlier one wins
      offer(nrt_pkg::ACT_MATCH, rgn(5, 100, 1020, 1000), 16'd0);
      offer(nrt_pkg::ACT_MATCH, rgn(15, 4194303, 65535, 65535), 16'd0);
      // zero pixel count never matches
      offer(nrt_pkg::ACT_MATCH, rgn(7, 0, 5000, 5000), 16'd0);
      // size ratio just above and exactly at three quarters
      offer(nrt_pkg::ACT_MATCH, rgn(9, 76, 20000, 20000), 16'd0);
      offer(nrt_pkg::ACT_MATCH, rgn(9, 75, 20000, 20000), 16'd0);
      // distance exactly at the limit, then one unit inside
      offer(nrt_pkg::ACT_MATCH, rgn(9, 100, 21600, 20000), 16'd0);
      offer(nrt_pkg::ACT_MATCH, rgn(9, 100, 21599, 20000), 16'd0);
      offer(nrt_pkg::ACT_MATCH, rgn(4, 100, 1000, 1000), 16'd0);
      offer(nrt_pkg::ACT_CLEAR, rgn(0, 0, 0, 0), 16'd0);
      offer(nrt_pkg::ACT_ADD, rgn(1, 1, 0, 65535), 16'd0);
      offer(nrt_pkg::ACT_START, rgn(0, 0, 0, 0), 16'd0);
      offer(nrt_pkg::ACT_START, rgn(0, 0, 0, 0), 16'd0);
      offer(nrt_pkg::ACT_MATCH, rgn(1, 1, 0, 65535), 16'd0);

      // random phases, each with its own distance limit
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: write_limit(12'd0);
            1: write_limit(12'd4095);
            2: write_limit(12'd100);
            3: write_limit(12'd1);
            5: write_limit(12'd7);
            default: write_limit(12'($urandom_range(2, 400)));
         endcase
         phase_end = items_sent + (ITEM_TARGET - 20) / PHASES;
         if (ph == 2) begin
            // long receiver hold-off while the sender keeps offering
            hold_off_req <= 1'b1;
            steady = 1'b1;
            random_frame(8);
            steady = 1'b0;
         end
         if (ph == 1 || ph == 4) begin
            // overfill the current list so appends are dropped
            random_frame(MAX_OBJECTS + 4);
         end
         while (items_sent < phase_end)
            random_frame($urandom_range(1, 8));
      end

      // drain
      req_tvalid <= 1'b0;
      while (open_items != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && open_items == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### nearest_region_id_tracker_core.f
design/nrt_pkg.sv
design/nrt_cell.sv
design/nrt_match.sv
design/nearest_region_id_tracker_core.sv
tb/region_track_checker.sv
tb/tb.sv
